/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the raster core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hw/rtl/bgr_pkg.sv */
// Types, constants and helpers for the bilinear gradient raster core.
package bgr_pkg;

   localparam int COUNT_WIDTH     = 10;
   localparam int COUNTER_LIMIT   = 1024;
   localparam int SIZE_WIDTH      = 11;
   localparam int COLOR_WIDTH     = 24;
   localparam int CHAN_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 24;
   localparam int MIN_SIZE        = 2;

   typedef logic [COUNT_WIDTH-1:0]    count_type;
   typedef logic [SIZE_WIDTH-1:0]     size_type;
   typedef logic [COLOR_WIDTH-1:0]    color_type;
   typedef logic [CHAN_WIDTH-1:0]     chan_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TOP_LEFT     = 3'd0,
      CSR_TOP_RIGHT    = 3'd1,
      CSR_BOTTOM_LEFT  = 3'd2,
      CSR_BOTTOM_RIGHT = 3'd3,
      CSR_FRAME_WIDTH  = 3'd4,
      CSR_FRAME_HEIGHT = 3'd5
   } csr_reg_type;

   typedef enum logic [1:0] {
      CHAN_RED,
      CHAN_GREEN,
      CHAN_BLUE
   } chan_sel_type;

   // One interpolation job: base + trunc((target - base) * num / den).
   typedef struct packed {
      chan_type  base;
      chan_type  target;
      count_type num;
      count_type den;
   } lerp_op_type;

   function automatic chan_type channel_of(color_type color, chan_sel_type sel);
      chan_type value;
      case (sel)
         CHAN_RED:   value = color[23:16];
         CHAN_GREEN: value = color[15:8];
         CHAN_BLUE:  value = color[7:0];
         default:    value = '0;
      endcase
      return value;
   endfunction

endpackage

/* hw/rtl/bgr_channels.sv */
// Request and response channel interfaces of the raster core.
interface bgr_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface bgr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bgr_pkg::COUNT_WIDTH-1:0] pixel_x;
   logic [bgr_pkg::COUNT_WIDTH-1:0] pixel_y;
   logic [bgr_pkg::CHAN_WIDTH-1:0]  red;
   logic [bgr_pkg::CHAN_WIDTH-1:0]  green;
   logic [bgr_pkg::CHAN_WIDTH-1:0]  blue;
   logic                          end_of_row;
   logic                          end_of_frame;

   modport source (output valid, output pixel_x, output pixel_y, output red, output green,
                   output blue, output end_of_row, output end_of_frame, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input red, input green,
                   input blue, input end_of_row, input end_of_frame, output ready);
endinterface

/* hw/rtl/bilinear_gradient_raster_core.sv */
// Top level of the bilinear gradient raster core: registers, position and op sequencer.
//
// Each beat on req_port (valid/ready) asks for one pixel; restart=1 emits pixel 0,0
// and restarts the frame, restart=0 emits the next pixel in raster order. Each pixel
// comes back as one beat on rsp_port with its column, row, red, green, blue and the
// end_of_row / end_of_frame flags. Corner colors and frame size are written through
// csr_write_enable / csr_index / csr_write_data; the user must write them only while
// the core is idle, as the core itself does not enforce it. Color math runs as nine
// interpolations per pixel (left, right, blend per channel) on one shared
// multiply-divide unit; req_port is not ready until the pixel is done. The next
// request is taken in the cycle after the result enters the output register.
// If the receiver stalls, the finished pixel holds in the output register; a second
// finished pixel waits in the core until that slot is free.
// Reset (synchronous, active high) restores the default corner colors, a 640x480
// frame and position 0,0, and empties the output register.
module bilinear_gradient_raster_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   bgr_req_if.sink                       req_port,
   bgr_rsp_if.source                     rsp_port,
   input  logic                          csr_write_enable,
   input  bgr_pkg::csr_index_type        csr_index,
   input  logic [bgr_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import bgr_pkg::*;
   `include "assert_macros.svh"

   localparam int WIDTH_HI  = (MAX_WIDTH < COUNTER_LIMIT) ? MAX_WIDTH : COUNTER_LIMIT;
   localparam int HEIGHT_HI = (MAX_HEIGHT < COUNTER_LIMIT) ? MAX_HEIGHT : COUNTER_LIMIT;
   localparam size_type WIDTH_HI_S  = size_type'(WIDTH_HI);
   localparam size_type HEIGHT_HI_S = size_type'(HEIGHT_HI);
   localparam size_type MIN_SIZE_S  = size_type'(MIN_SIZE);

   typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_WAIT} state_type;
   typedef enum logic [1:0] {PART_LEFT, PART_RIGHT, PART_MIX} part_type;

   // Configuration registers
   color_type top_left_ff;
   color_type top_right_ff;
   color_type bottom_left_ff;
   color_type bottom_right_ff;
   size_type  frame_width_ff;
   size_type  frame_height_ff;

   // Sequencer and position state
   state_type    state_ff;
   part_type     part_ff;
   chan_sel_type chan_ff;
   logic         start_ff;
   count_type    col_ff;
   count_type    row_ff;
   count_type    cur_col_ff;
   count_type    cur_row_ff;
   logic         eor_ff;
   logic         eof_ff;
   count_type    wm1_ff;
   count_type    hm1_ff;
   chan_type     left_ff;
   chan_type     right_ff;
   chan_type     red_ff;
   chan_type     green_ff;
   chan_type     blue_ff;

   // Output register
   logic      rsp_valid_ff;
   count_type rsp_x_ff;
   count_type rsp_y_ff;
   chan_type  rsp_red_ff;
   chan_type  rsp_green_ff;
   chan_type  rsp_blue_ff;
   logic      rsp_eor_ff;
   logic      rsp_eof_ff;

   size_type    w_eff;
   size_type    h_eff;
   count_type   wm1;
   count_type   hm1;
   count_type   col0;
   count_type   row0;
   count_type   col1;
   count_type   row_wrap;
   count_type   row1;
   logic        eor;
   logic        eof;
   count_type   col_in;
   count_type   row_in;
   logic        req_accept;
   logic        lerp_done;
   chan_type    lerp_result;
   lerp_op_type lerp_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_left_ff     <= 24'hFF0000;
         top_right_ff    <= 24'h0000FF;
         bottom_left_ff  <= 24'h00FF00;
         bottom_right_ff <= 24'hFFFF00;
         frame_width_ff  <= 11'd640;
         frame_height_ff <= 11'd480;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TOP_LEFT:     top_left_ff     <= csr_write_data;
            CSR_TOP_RIGHT:    top_right_ff    <= csr_write_data;
            CSR_BOTTOM_LEFT:  bottom_left_ff  <= csr_write_data;
            CSR_BOTTOM_RIGHT: bottom_right_ff <= csr_write_data;
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data[SIZE_WIDTH-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data[SIZE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the frame size and find the position of this pixel.
   always_comb begin
      if (frame_width_ff < MIN_SIZE_S)       w_eff = MIN_SIZE_S;
      else if (frame_width_ff > WIDTH_HI_S)  w_eff = WIDTH_HI_S;
      else                                   w_eff = frame_width_ff;
      if (frame_height_ff < MIN_SIZE_S)      h_eff = MIN_SIZE_S;
      else if (frame_height_ff > HEIGHT_HI_S) h_eff = HEIGHT_HI_S;
      else                                   h_eff = frame_height_ff;
      wm1 = count_type'(w_eff - 11'd1);
      hm1 = count_type'(h_eff - 11'd1);

      col0 = req_port.restart ? '0 : col_ff;
      row0 = req_port.restart ? '0 : row_ff;
      // Frame may have shrunk: move to the next row, then wrap the row.
      if ({1'b0, col0} >= w_eff) begin
         col1     = '0;
         row_wrap = row0 + 10'd1;
      end else begin
         col1     = col0;
         row_wrap = row0;
      end
      row1 = ({1'b0, row_wrap} >= h_eff) ? '0 : row_wrap;

      eor = (col1 == wm1);
      eof = eor && (row1 == hm1);
      if (eor) begin
         col_in = '0;
         row_in = eof ? '0 : (row1 + 10'd1);
      end else begin
         col_in = col1 + 10'd1;
         row_in = row1;
      end
   end

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_port.valid && (state_ff == ST_IDLE);

   always_comb begin
      case (part_ff)
         PART_LEFT: begin
            lerp_op.base   = channel_of(top_left_ff, chan_ff);
            lerp_op.target = channel_of(bottom_left_ff, chan_ff);
            lerp_op.num    = cur_row_ff;
            lerp_op.den    = hm1_ff;
         end
         PART_RIGHT: begin
            lerp_op.base   = channel_of(top_right_ff, chan_ff);
            lerp_op.target = channel_of(bottom_right_ff, chan_ff);
            lerp_op.num    = cur_row_ff;
            lerp_op.den    = hm1_ff;
         end
         PART_MIX: begin
            lerp_op.base   = left_ff;
            lerp_op.target = right_ff;
            lerp_op.num    = cur_col_ff;
            lerp_op.den    = wm1_ff;
         end
         default: begin
            lerp_op.base   = '0;
            lerp_op.target = '0;
            lerp_op.num    = '0;
            lerp_op.den    = wm1_ff;
         end
      endcase
   end

   bgr_lerp_unit u_lerp (
      .clock  (clock),
      .reset  (reset),
      .start  (start_ff),
      .op     (lerp_op),
      .done   (lerp_done),
      .result (lerp_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         part_ff      <= PART_LEFT;
         chan_ff      <= CHAN_RED;
         start_ff     <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  col_ff     <= col_in;
                  row_ff     <= row_in;
                  cur_col_ff <= col1;
                  cur_row_ff <= row1;
                  eor_ff     <= eor;
                  eof_ff     <= eof;
                  wm1_ff     <= wm1;
                  hm1_ff     <= hm1;
                  part_ff    <= PART_LEFT;
                  chan_ff    <= CHAN_RED;
                  start_ff   <= 1'b1;
                  state_ff   <= ST_CALC;
               end
            end
            ST_CALC: begin
               if (lerp_done) begin
                  case (part_ff)
                     PART_LEFT: begin
                        left_ff  <= lerp_result;
                        part_ff  <= PART_RIGHT;
                        start_ff <= 1'b1;
                     end
                     PART_RIGHT: begin
                        right_ff <= lerp_result;
                        part_ff  <= PART_MIX;
                        start_ff <= 1'b1;
                     end
                     default: begin
                        case (chan_ff)
                           CHAN_RED: begin
                              red_ff   <= lerp_result;
                              chan_ff  <= CHAN_GREEN;
                              part_ff  <= PART_LEFT;
                              start_ff <= 1'b1;
                           end
                           CHAN_GREEN: begin
                              green_ff <= lerp_result;
                              chan_ff  <= CHAN_BLUE;
                              part_ff  <= PART_LEFT;
                              start_ff <= 1'b1;
                           end
                           default: begin
                              blue_ff  <= lerp_result;
                              state_ff <= ST_WAIT;
                           end
                        endcase
                     end
                  endcase
               end
            end
            ST_WAIT: begin
               // Hold the pixel until the output register is free.
               if (!rsp_valid_ff || rsp_port.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_x_ff     <= cur_col_ff;
                  rsp_y_ff     <= cur_row_ff;
                  rsp_red_ff   <= red_ff;
                  rsp_green_ff <= green_ff;
                  rsp_blue_ff  <= blue_ff;
                  rsp_eor_ff   <= eor_ff;
                  rsp_eof_ff   <= eof_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.pixel_x      = rsp_x_ff;
   assign rsp_port.pixel_y      = rsp_y_ff;
   assign rsp_port.red          = rsp_red_ff;
   assign rsp_port.green        = rsp_green_ff;
   assign rsp_port.blue         = rsp_blue_ff;
   assign rsp_port.end_of_row   = rsp_eor_ff;
   assign rsp_port.end_of_frame = rsp_eof_ff;

   `ASSERT_CLK(a_start_in_calc, clock, reset, start_ff |-> (state_ff == ST_CALC),
      "interpolation started outside a pixel")
   `ASSERT_CLK(a_pos_in_frame, clock, reset,
      (state_ff == ST_CALC) |-> ((cur_col_ff <= wm1_ff) && (cur_row_ff <= hm1_ff)),
      "pixel position outside the frame")
   `ASSERT_NEVER(a_eof_without_eor, clock, reset, rsp_valid_ff && rsp_eof_ff && !rsp_eor_ff,
      "end of frame flagged off the end of a row")
endmodule

/* hw/rtl/bgr_lerp_unit.sv */
// Shared interpolation unit: multiply, then radix-4 restoring divide.
module bgr_lerp_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  bgr_pkg::lerp_op_type op,
   output logic                 done,
   output bgr_pkg::chan_type    result
);
   import bgr_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type   state_ff;
   logic [1:0]  step_ff;
   count_type   rem_ff;
   chan_type    bits_ff;
   logic        neg_ff;
   chan_type    base_ff;
   count_type   den_ff;
   logic        done_ff;
   chan_type    result_ff;

   logic signed [8:0]  diff;
   logic signed [10:0] num_s;
   logic signed [19:0] prod;
   logic [19:0]        mag_full;
   logic [17:0]        mag;
   logic [10:0]        trial1;
   logic [10:0]        trial2;
   logic               ge1;
   logic               ge2;
   count_type          rem1;
   count_type          rem2;
   chan_type           bits_in;
   logic [9:0]         quot_s;
   logic [9:0]         sum;
   chan_type           result_in;

   assign diff     = $signed({1'b0, op.target}) - $signed({1'b0, op.base});
   assign num_s    = $signed({1'b0, op.num});
   assign prod     = diff * num_s;
   assign mag_full = prod[19] ? 20'(-prod) : 20'(prod);
   assign mag      = mag_full[17:0];

   // Two quotient bits per cycle; remainder stays below the divisor.
   assign trial1  = {rem_ff, bits_ff[7]};
   assign ge1     = trial1 >= {1'b0, den_ff};
   assign rem1    = ge1 ? count_type'(trial1 - {1'b0, den_ff}) : trial1[9:0];
   assign trial2  = {rem1, bits_ff[6]};
   assign ge2     = trial2 >= {1'b0, den_ff};
   assign rem2    = ge2 ? count_type'(trial2 - {1'b0, den_ff}) : trial2[9:0];
   assign bits_in = {bits_ff[5:0], ge1, ge2};

   assign quot_s    = neg_ff ? 10'(-{2'b00, bits_in}) : {2'b00, bits_in};
   assign sum       = {2'b00, base_ff} + quot_s;
   assign result_in = sum[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  // Quotient fits 8 bits, so the top bits start as the remainder.
                  rem_ff   <= mag[17:8];
                  bits_ff  <= mag[7:0];
                  neg_ff   <= prod[19];
                  base_ff  <= op.base;
                  den_ff   <= op.den;
                  step_ff  <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               rem_ff  <= rem2;
               bits_ff <= bits_in;
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  result_ff <= result_in;
                  done_ff   <= 1'b1;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

   `ASSERT_CLK(a_rem_below_den, clock, reset, (state_ff == ST_RUN) |-> (rem_ff < den_ff),
      "lerp unit remainder not below divisor")
   `ASSERT_CLK(a_done_after_run, clock, reset, done_ff |-> $past(state_ff == ST_RUN),
      "lerp unit done without a divide")
endmodule
